// File: sv/heading_to_velocity_command_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for heading_to_velocity_command
// Short forms for clocked assertions with reset masking.
// ----------------------------------------------------------------------------
`ifndef HEADING_TO_VELOCITY_COMMAND_ASSERT_SVH
`define HEADING_TO_VELOCITY_COMMAND_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heading_to_velocity_command: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HVC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heading_to_velocity_command: next-cycle check failed");

`endif

// File: sv/hvc_pkg.sv
// ----------------------------------------------------------------------------
// hvc_pkg
// Types, constants and tables of the heading to velocity command block.
// ----------------------------------------------------------------------------
package hvc_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT_Q,
		S_ROT_T,
		S_WRAP,
		S_TURN,
		S_SQX,
		S_SQY,
		S_SQRT,
		S_EXP,
		S_LEN,
		S_SPD,
		S_CMP,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_ANG_GAIN   = 3'd0,
		REG_LIN_GAIN   = 3'd1,
		REG_MIN_SPEED  = 3'd2,
		REG_MAX_SPEED  = 3'd3,
		REG_CHG_FACTOR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [26:0] x;
		logic signed [26:0] y;
		logic signed [20:0] z;
		logic               zero;
	} cordic_init_t;

	localparam logic signed [21:0] PI_Q      = 22'sd205887;
	localparam logic signed [21:0] TWO_PI_Q  = 22'sd411774;
	localparam logic [4:0]         WRAP_LAST = 5'd5;
	localparam logic [4:0]         BIT_LAST  = 5'd15;
	// ceil(2^19 / 3): floor(v / 3) = (v * RECIP3) >> 19 for v below 2^19.
	localparam logic [17:0]        RECIP3    = 18'd174763;

	function automatic logic [15:0] atan_lut(input logic [4:0] i);
		logic [15:0] r;
		case (i)
			5'd0:    r = 16'd51472;
			5'd1:    r = 16'd30385;
			5'd2:    r = 16'd16055;
			5'd3:    r = 16'd8150;
			5'd4:    r = 16'd4091;
			5'd5:    r = 16'd2047;
			5'd6:    r = 16'd1024;
			5'd7:    r = 16'd512;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] exp_lut(input logic [3:0] k);
		logic [15:0] r;
		case (k)
			4'd0:    r = 16'd65520;
			4'd1:    r = 16'd65504;
			4'd2:    r = 16'd65472;
			4'd3:    r = 16'd65408;
			4'd4:    r = 16'd65280;
			4'd5:    r = 16'd65026;
			4'd6:    r = 16'd64520;
			4'd7:    r = 16'd63520;
			4'd8:    r = 16'd61565;
			4'd9:    r = 16'd57835;
			4'd10:   r = 16'd51039;
			4'd11:   r = 16'd39750;
			4'd12:   r = 16'd24109;
			4'd13:   r = 16'd8869;
			4'd14:   r = 16'd1200;
			default: r = 16'd22;
		endcase
		return r;
	endfunction

	// Operands scaled by 256; a negative x is turned by pi first.
	function automatic cordic_init_t cordic_load(input logic [15:0] y16,
		input logic [15:0] x16);
		cordic_init_t c;
		logic signed [26:0] xi;
		logic signed [26:0] yi;
		xi = {{3{x16[15]}}, x16, 8'd0};
		yi = {{3{y16[15]}}, y16, 8'd0};
		c.zero = (x16 == 16'd0) && (y16 == 16'd0);
		c.z = '0;
		c.x = xi;
		c.y = yi;
		if (xi < 0) begin
			c.z = yi[26] ? -21'(PI_Q) : 21'(PI_Q);
			c.x = -xi;
			c.y = -yi;
		end
		return c;
	endfunction

endpackage

// File: sv/heading_to_velocity_command.sv
// ----------------------------------------------------------------------------
// heading_to_velocity_command
// The sequencer takes one item at a time: a new input is accepted only after
// the last result has been delivered, and an extra divide step follows when
// the speed is blended. A shared multiplier and the CORDIC rotator work
// under one sequencer.
// Reset: asynchronous, clears the sequencer, the previous speed and loads
// the default register values.
// ----------------------------------------------------------------------------
module heading_to_velocity_command #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // target_x, target_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // turn_rate, forward_speed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import hvc_pkg::*;

	localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);

	state_t state_q, state_d;

	logic [15:0] ang_gain_q, lin_gain_q, min_speed_q, max_speed_q, chg_factor_q;
	logic [15:0] prev_q;
	logic [4:0]  cnt_q;

	logic [15:0] tx_q, ty_q;
	logic signed [26:0] x_q, y_q;
	logic signed [20:0] z_q;
	logic               zero_q;
	logic signed [20:0] yaw_q;
	logic signed [21:0] err_q;
	logic [15:0] turn_q, mag_q;
	logic [31:0] sq_q, rad_q, root_q;
	logic [16:0] e_q;
	logic [31:0] lp_q;
	logic [15:0] spd_q;
	logic [17:0] v_q;

	logic signed [32:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [51:0] mul_p;

	cordic_init_t       ld_q, ld_t;
	logic signed [26:0] xs, ys, x_n, y_n;
	logic signed [20:0] z_n, z_res;
	logic signed [20:0] atan_v;

	logic signed [51:0] tsum, tsh;
	logic [15:0]        turn_n;
	logic [31:0]        bit_v;
	logic [32:0]        trial;
	logic [33:0]        e_prod;
	logic [48:0]        ssum;
	logic [21:0]        s_pre;
	logic [15:0]        s_cap;
	logic [15:0]        diff;
	logic [31:0]        lhs;
	logic               need_blend;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {spd_q, turn_q};

	// Shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TURN: begin
				mul_a = {{11{err_q[21]}}, err_q};
				mul_b = {3'd0, ang_gain_q};
			end
			S_SQX: begin
				mul_a = {{17{tx_q[15]}}, tx_q};
				mul_b = {{3{tx_q[15]}}, tx_q};
			end
			S_SQY: begin
				mul_a = {{17{ty_q[15]}}, ty_q};
				mul_b = {{3{ty_q[15]}}, ty_q};
			end
			S_EXP: begin
				mul_a = {16'd0, e_q};
				mul_b = {3'd0, exp_lut(cnt_q[3:0])};
			end
			S_LEN: begin
				mul_a = {17'd0, lin_gain_q};
				mul_b = {3'd0, root_q[15:0]};
			end
			S_SPD: begin
				mul_a = {1'b0, lp_q};
				mul_b = {2'd0, e_q};
			end
			S_CMP: begin
				mul_a = {17'd0, chg_factor_q};
				mul_b = {3'd0, prev_q};
			end
			S_DIV: begin
				mul_a = {15'd0, v_q};
				mul_b = {1'b0, RECIP3};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// CORDIC rotator, one micro-rotation a cycle.
	assign ld_q   = cordic_load(s_tdata[47:32], s_tdata[63:48]);
	assign ld_t   = cordic_load(ty_q, tx_q);
	assign atan_v = {5'd0, atan_lut(cnt_q)};
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	always_comb begin
		if (y_q < 0) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_v;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_v;
		end
		z_res = zero_q ? '0 : z_n;
	end

	// Turn rate rounding and saturation.
	always_comb begin
		tsum = mul_p + 52'sd32768;
		tsh  = tsum >>> 16;
		if (tsh > 52'sd32767)
			turn_n = 16'h7FFF;
		else if (tsh < -52'sd32768)
			turn_n = 16'h8000;
		else
			turn_n = tsh[15:0];
	end

	// Square root and exponential steps.
	assign bit_v  = 32'h4000_0000 >> {cnt_q[3:0], 1'b0};
	assign trial  = {1'b0, root_q} + {1'b0, bit_v};
	assign e_prod = mul_p[33:0] + 34'd32768;

	// Speed, cap and blend test.
	always_comb begin
		ssum  = mul_p[48:0] + 49'h800_0000;
		s_pre = {1'b0, ssum[48:28]} + {6'd0, min_speed_q};
		s_cap = (s_pre > {6'd0, max_speed_q}) ? max_speed_q : s_pre[15:0];
		diff  = (spd_q > prev_q) ? spd_q - prev_q : prev_q - spd_q;
		lhs   = {4'd0, diff, 12'd0};
		need_blend = lhs > mul_p[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = S_ROT_Q;
			end
			S_ROT_Q: if (cnt_q == ROT_LAST) state_d = S_ROT_T;
			S_ROT_T: if (cnt_q == ROT_LAST) state_d = S_WRAP;
			S_WRAP:  if (cnt_q == WRAP_LAST) state_d = S_TURN;
			S_TURN:  state_d = S_SQX;
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_SQRT;
			S_SQRT:  if (cnt_q == BIT_LAST) state_d = S_EXP;
			S_EXP:   if (cnt_q == BIT_LAST) state_d = S_LEN;
			S_LEN:   state_d = S_SPD;
			S_SPD:   state_d = S_CMP;
			S_CMP:   state_d = need_blend ? S_DIV : S_OUT;
			S_DIV:   state_d = S_OUT;
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: configuration, previous speed, step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_gain_q   <= 16'd4096;
			lin_gain_q   <= 16'd4096;
			min_speed_q  <= 16'd410;
			max_speed_q  <= 16'd4096;
			chg_factor_q <= 16'd4096;
			prev_q       <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ANG_GAIN:   ang_gain_q   <= cfg_data;
					REG_LIN_GAIN:   lin_gain_q   <= cfg_data;
					REG_MIN_SPEED:  min_speed_q  <= cfg_data;
					REG_MAX_SPEED:  max_speed_q  <= cfg_data;
					REG_CHG_FACTOR: chg_factor_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_CMP && !need_blend)
				prev_q <= spd_q;
			else if (state_q == S_DIV)
				prev_q <= mul_p[34:19];
			if (state_d != state_q)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 5'd1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tx_q   <= s_tdata[15:0];
				ty_q   <= s_tdata[31:16];
				x_q    <= ld_q.x;
				y_q    <= ld_q.y;
				z_q    <= ld_q.z;
				zero_q <= ld_q.zero;
			end
			S_ROT_Q: begin
				if (cnt_q == ROT_LAST) begin
					yaw_q  <= z_res;
					x_q    <= ld_t.x;
					y_q    <= ld_t.y;
					z_q    <= ld_t.z;
					zero_q <= ld_t.zero;
				end else begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
				end
			end
			S_ROT_T: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				if (cnt_q == ROT_LAST)
					err_q <= {z_res[20], z_res} - {yaw_q, 1'b0};
			end
			S_WRAP: begin
				// First three steps pull down from above pi, then three push up.
				if (cnt_q < 5'd3) begin
					if (err_q > PI_Q)
						err_q <= err_q - TWO_PI_Q;
				end else if (err_q < -PI_Q) begin
					err_q <= err_q + TWO_PI_Q;
				end
			end
			S_TURN: begin
				turn_q <= turn_n;
				mag_q  <= turn_n[15] ? 16'(-turn_n) : turn_n;
			end
			S_SQX: sq_q <= mul_p[31:0];
			S_SQY: begin
				rad_q  <= sq_q + mul_p[31:0];
				root_q <= '0;
			end
			S_SQRT: begin
				if ({1'b0, rad_q} >= trial) begin
					rad_q  <= rad_q - trial[31:0];
					root_q <= (root_q >> 1) + bit_v;
				end else begin
					root_q <= root_q >> 1;
				end
				e_q <= 17'h10000;
			end
			S_EXP: begin
				if (mag_q[cnt_q[3:0]])
					e_q <= e_prod[32:16];
			end
			S_LEN: lp_q <= mul_p[31:0];
			S_SPD: spd_q <= s_cap;
			S_CMP: v_q <= {2'd0, spd_q} + {1'b0, prev_q, 1'b0} + 18'd1;
			S_DIV: spd_q <= mul_p[34:19];
			default: ;
		endcase
	end

	`include "heading_to_velocity_command_assert.svh"

	`HVC_ASSERT_NOW(a_no_accept_while_result, m_tvalid, !s_tready)
	`HVC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !m_tvalid)
	`HVC_ASSERT_NEXT(a_idle_after_delivery, m_tvalid && m_tready, s_tready && !m_tvalid)

endmodule
